>>> sv/qsv_pkg.sv
// ----------------------------------------------------------------------------
// qsv_pkg
// Shared codes, field widths and controller/datapath interface types for the
// state-vector gate core.
// ----------------------------------------------------------------------------
package qsv_pkg;

    // input item field widths
    localparam int OPC_W      = 3;
    localparam int TQ_W       = 3;
    localparam int RI_W       = 5;
    localparam int IN_TDATA_W = 16;

    // configuration register
    localparam int            CFG_W        = 3;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd5;

    // opcodes
    localparam logic [OPC_W-1:0] OP_RESET    = 3'd0;
    localparam logic [OPC_W-1:0] OP_HADAMARD = 3'd1;
    localparam logic [OPC_W-1:0] OP_PAULI_X  = 3'd2;
    localparam logic [OPC_W-1:0] OP_PAULI_Z  = 3'd3;
    localparam logic [OPC_W-1:0] OP_READ     = 3'd4;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PAIR_RD,
        S_PAIR_SUM,
        S_PAIR_MUL,
        S_PAIR_WR0,
        S_PAIR_WR1,
        S_READ,
        S_SQUARE,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;    // latch the input item
        logic cnt_clr;   // clear the entry/pair counter
        logic cnt_inc;   // advance the entry/pair counter
        logic clr_we;    // clearing pass write
        logic cap_sum;   // capture pair operands and sums
        logic cap_mul;   // capture scaled products
        logic wr_lo;     // write the entry with the target bit clear
        logic wr_hi;     // write the entry with the target bit set
        logic rd_read;   // address the store with the read index
        logic cap_sq;    // capture amplitude and squares
        logic out_load;  // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OPC_W-1:0] op;
        logic             gate_skip;
        logic             last_pair;
        logic             last_clear;
        logic             out_busy;
    } t_status;

endpackage

>>> sv/qsv_ram.sv
// ----------------------------------------------------------------------------
// qsv_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module qsv_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> sv/qsv_dp.sv
// ----------------------------------------------------------------------------
// qsv_dp
// Datapath: amplitude stores, pair addressing, Hadamard scaling, negation,
// probability and the result register.
// ----------------------------------------------------------------------------
module qsv_dp #(
    parameter int  NUM_QUBITS  = 5,
    parameter int  FRAC_BITS   = 16,
    localparam int OUT_TDATA_W = (((3 * (FRAC_BITS + 2) - 1) + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [qsv_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic [qsv_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  qsv_pkg::t_cmd                i_cmd,
    output qsv_pkg::t_status             o_sts,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata
);

    import qsv_pkg::*;

    localparam int AW    = NUM_QUBITS;
    localparam int DEPTH = 1 << NUM_QUBITS;
    localparam int W     = FRAC_BITS + 2;
    localparam int NW    = $clog2(NUM_QUBITS + 1);
    localparam int SW    = W + 1;
    localparam int KW    = FRAC_BITS + 1;
    localparam int PW    = SW + KW;
    localparam int PRW   = FRAC_BITS + 1;

    // 1/sqrt2 rounded to FRAC_BITS fraction bits
    localparam logic [63:0] KQ =
        (64'd3037000500 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic signed [KW-1:0] K_INV_SQRT2 = {1'b0, KQ[FRAC_BITS-1:0]};

    localparam logic signed [W+1:0] WMAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] WMIN = {3'b111, {(W-1){1'b0}}};
    localparam logic signed [PW-1:0] RHALF =
        {{(PW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] RHALF_M1 = RHALF - PW'(1);
    localparam logic [W-1:0]   ONE_W = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [2*W-1:0] PHALF = {{(2*W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
    localparam logic [PRW-1:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};

    // saturate to the word range
    function automatic logic [W-1:0] sat_word(input logic signed [W+1:0] v);
        logic [W-1:0] res;
        if (v > WMAX) begin
            res = WMAX[W-1:0];
        end else if (v < WMIN) begin
            res = WMIN[W-1:0];
        end else begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    // shift right by FRAC_BITS, half away from zero, then saturate
    function automatic logic [W-1:0] scale_round(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = p + (p[PW-1] ? RHALF_M1 : RHALF);
        return sat_word($signed(t[PW-1:FRAC_BITS]));
    endfunction

    // negate with saturation
    function automatic logic [W-1:0] neg_word(input logic [W-1:0] b);
        logic signed [W+1:0] nb;
        nb = -$signed({{2{b[W-1]}}, b});
        return sat_word(nb);
    endfunction

    logic [CFG_W-1:0] r_act;
    logic [OPC_W-1:0] r_op;
    logic [TQ_W-1:0]  r_tq;
    logic [RI_W-1:0]  r_ri;
    logic [AW-1:0]    r_cnt;

    logic [NW-1:0] act_qubits;
    logic [AW:0]   vec_len;
    logic [AW-1:0] low_mask;
    logic [AW-1:0] bit_mask;
    logic [AW-1:0] addr_i;
    logic [AW-1:0] addr_j;
    logic          read_oob;

    logic [W-1:0]  ram_re_a, ram_re_b, ram_im_a, ram_im_b;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr_a;
    logic [W-1:0]  ram_wdata_re, ram_wdata_im;

    logic signed [SW-1:0] r_sum_re, r_dif_re, r_sum_im, r_dif_im;
    logic [W-1:0]         r_a_re, r_a_im, r_b_re, r_b_im;
    logic signed [PW-1:0] r_p_sr, r_p_dr, r_p_si, r_p_di;

    logic [W-1:0]           r_re, r_im;
    logic signed [2*W-1:0]  r_sq_re, r_sq_im;
    logic [2*W-1:0]         prob_sum;
    logic [2*W-FRAC_BITS-1:0] prob_shift;
    logic [PRW-1:0]         prob_sat;

    logic           r_out_valid;
    logic [W-1:0]   r_out_re, r_out_im;
    logic [PRW-1:0] r_out_prob;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_act <= i_cfg_wdata;
        end
    end

    // active qubit count, clamped to 1..NUM_QUBITS
    always_comb begin
        if (r_act == '0) begin
            act_qubits = NW'(1);
        end else if (r_act > NUM_QUBITS) begin
            act_qubits = NW'(NUM_QUBITS);
        end else begin
            act_qubits = NW'(r_act);
        end
    end

    assign vec_len  = (AW+1)'(1) << act_qubits;
    assign read_oob = (r_ri >= vec_len);

    // input item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_s_tdata[OPC_W-1:0];
            r_tq <= i_s_tdata[OPC_W+TQ_W-1:OPC_W];
            r_ri <= i_s_tdata[OPC_W+TQ_W+RI_W-1:OPC_W+TQ_W];
        end
    end

    // entry / pair counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // pair addresses: insert a zero or a one at the target bit
    assign bit_mask = AW'(1) << r_tq;
    assign low_mask = bit_mask - AW'(1);
    assign addr_i   = ((r_cnt & ~low_mask) << 1) | (r_cnt & low_mask);
    assign addr_j   = addr_i | bit_mask;

    assign ram_raddr_a = i_cmd.rd_read ? AW'(r_ri) : addr_i;

    // store write port selection
    always_comb begin
        ram_we       = i_cmd.clr_we | i_cmd.wr_lo | i_cmd.wr_hi;
        ram_waddr    = r_cnt;
        ram_wdata_re = '0;
        ram_wdata_im = '0;
        if (i_cmd.clr_we) begin
            ram_waddr    = r_cnt;
            ram_wdata_re = (r_cnt == '0) ? ONE_W : '0;
            ram_wdata_im = '0;
        end else if (i_cmd.wr_lo) begin
            ram_waddr = addr_i;
            case (r_op)
                OP_HADAMARD: begin
                    ram_wdata_re = scale_round(r_p_sr);
                    ram_wdata_im = scale_round(r_p_si);
                end
                OP_PAULI_X: begin
                    ram_wdata_re = r_b_re;
                    ram_wdata_im = r_b_im;
                end
                default: begin
                    ram_wdata_re = r_a_re;
                    ram_wdata_im = r_a_im;
                end
            endcase
        end else if (i_cmd.wr_hi) begin
            ram_waddr = addr_j;
            case (r_op)
                OP_HADAMARD: begin
                    ram_wdata_re = scale_round(r_p_dr);
                    ram_wdata_im = scale_round(r_p_di);
                end
                OP_PAULI_X: begin
                    ram_wdata_re = r_a_re;
                    ram_wdata_im = r_a_im;
                end
                default: begin
                    ram_wdata_re = neg_word(r_b_re);
                    ram_wdata_im = neg_word(r_b_im);
                end
            endcase
        end
    end

    qsv_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram_re (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (addr_j),
        .o_rdata_a (ram_re_a),
        .o_rdata_b (ram_re_b)
    );

    qsv_ram #(
        .WIDTH (W),
        .DEPTH (DEPTH)
    ) u_ram_im (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata_im),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (addr_j),
        .o_rdata_a (ram_im_a),
        .o_rdata_b (ram_im_b)
    );

    // pair operands, sums and differences
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_sum) begin
            r_a_re   <= ram_re_a;
            r_a_im   <= ram_im_a;
            r_b_re   <= ram_re_b;
            r_b_im   <= ram_im_b;
            r_sum_re <= $signed({ram_re_a[W-1], ram_re_a}) + $signed({ram_re_b[W-1], ram_re_b});
            r_dif_re <= $signed({ram_re_a[W-1], ram_re_a}) - $signed({ram_re_b[W-1], ram_re_b});
            r_sum_im <= $signed({ram_im_a[W-1], ram_im_a}) + $signed({ram_im_b[W-1], ram_im_b});
            r_dif_im <= $signed({ram_im_a[W-1], ram_im_a}) - $signed({ram_im_b[W-1], ram_im_b});
        end
    end

    // scale by 1/sqrt2
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_mul) begin
            r_p_sr <= r_sum_re * K_INV_SQRT2;
            r_p_dr <= r_dif_re * K_INV_SQRT2;
            r_p_si <= r_sum_im * K_INV_SQRT2;
            r_p_di <= r_dif_im * K_INV_SQRT2;
        end
    end

    // amplitude and squares for a read
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_sq) begin
            r_re    <= ram_re_a;
            r_im    <= ram_im_a;
            r_sq_re <= $signed(ram_re_a) * $signed(ram_re_a);
            r_sq_im <= $signed(ram_im_a) * $signed(ram_im_a);
        end
    end

    // probability: round to FRAC_BITS and saturate at one
    assign prob_sum   = {1'b0, r_sq_re[2*W-2:0]} + {1'b0, r_sq_im[2*W-2:0]} + PHALF;
    assign prob_shift = prob_sum[2*W-1:FRAC_BITS];
    assign prob_sat   = (prob_shift > ONE_P) ? ONE_P : prob_shift[PRW-1:0];

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_re   <= read_oob ? '0 : r_re;
            r_out_im   <= read_oob ? '0 : r_im;
            r_out_prob <= read_oob ? '0 : prob_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_prob, r_out_im, r_out_re});

    // status back to the controller
    assign o_sts.op         = r_op;
    assign o_sts.gate_skip  = (r_tq >= act_qubits);
    assign o_sts.last_pair  = (r_cnt == (vec_len[AW:1] - AW'(1)));
    assign o_sts.last_clear = &r_cnt;
    assign o_sts.out_busy   = r_out_valid & ~i_m_tready;

endmodule

>>> sv/qsv_ctrl.sv
// ----------------------------------------------------------------------------
// qsv_ctrl
// Controller: sequences the clearing pass, the pair sweep of a gate and the
// read of one amplitude.
// ----------------------------------------------------------------------------
module qsv_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output qsv_pkg::t_cmd    o_cmd,
    input  qsv_pkg::t_status i_sts
);

    import qsv_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register, reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.last_clear) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.op) inside
                    OP_RESET: n_state = S_CLEAR;
                    OP_HADAMARD, OP_PAULI_X, OP_PAULI_Z: begin
                        n_state = i_sts.gate_skip ? S_IDLE : S_PAIR_RD;
                    end
                    OP_READ: n_state = S_READ;
                    default: n_state = S_IDLE;
                endcase
            end
            S_PAIR_RD:  n_state = S_PAIR_SUM;
            S_PAIR_SUM: n_state = S_PAIR_MUL;
            S_PAIR_MUL: n_state = S_PAIR_WR0;
            S_PAIR_WR0: n_state = S_PAIR_WR1;
            S_PAIR_WR1: begin
                n_state = i_sts.last_pair ? S_IDLE : S_PAIR_RD;
            end
            S_READ:   n_state = S_SQUARE;
            S_SQUARE: n_state = S_RESULT;
            S_RESULT: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we  = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.accept  = i_s_tvalid;
                o_cmd.cnt_clr = 1'b1;
            end
            S_PAIR_SUM: o_cmd.cap_sum = 1'b1;
            S_PAIR_MUL: o_cmd.cap_mul = 1'b1;
            S_PAIR_WR0: o_cmd.wr_lo   = 1'b1;
            S_PAIR_WR1: begin
                o_cmd.wr_hi   = 1'b1;
                o_cmd.cnt_inc = 1'b1;
            end
            S_READ:   o_cmd.rd_read = 1'b1;
            S_SQUARE: o_cmd.cap_sq  = 1'b1;
            S_RESULT: o_cmd.out_load = ~i_sts.out_busy;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/quantum_state_vector_gates_core.sv
// ----------------------------------------------------------------------------
// quantum_state_vector_gates_core
// State-vector gate core: Hadamard, Pauli-X, Pauli-Z and amplitude read over
// 2^NUM_QUBITS complex fixed-point amplitudes.
// ----------------------------------------------------------------------------
// One item at a time. After reset, and for every reset opcode, a clearing pass
// writes basis state zero into the whole store, during which s_axis_tready
// stays low. A gate on n active qubits sweeps the 2^(n-1) amplitude pairs,
// each in the steps read both entries, add, scale, then two writes through
// the single write port of each store. A read waits for the result register
// to drain. The result register holds one read while the next item is
// accepted.
module quantum_state_vector_gates_core #(
    parameter int  NUM_QUBITS  = 5,
    parameter int  FRAC_BITS   = 16,
    localparam int OUT_TDATA_W = (((3 * (FRAC_BITS + 2) - 1) + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration: active_qubits
    input  logic                           i_cfg_we,
    input  logic [qsv_pkg::CFG_W-1:0]      i_cfg_wdata,
    // input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode [2:0], target_qubit [5:3], read_index [10:6]
    input  logic [qsv_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // real_part, imag_part (FRAC_BITS+2 each), probability (FRAC_BITS+1)
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata
);

    import qsv_pkg::*;

    t_cmd    cmd;
    t_status sts;

    // controller
    qsv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath
    qsv_dp #(
        .NUM_QUBITS (NUM_QUBITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

>>> sv/qsv_checker.sv
// ----------------------------------------------------------------------------
// qsv_checker
// Port-level checks for the state-vector gate core, bound to the top level.
// ----------------------------------------------------------------------------
module qsv_checker #(
    parameter int  FRAC_BITS   = 16,
    localparam int OUT_TDATA_W = (((3 * (FRAC_BITS + 2) - 1) + 7) / 8) * 8
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [OUT_TDATA_W-1:0]         m_axis_tdata
);

    localparam int W   = FRAC_BITS + 2;
    localparam int PRW = FRAC_BITS + 1;
    localparam logic [PRW-1:0] ONE_P = {1'b1, {FRAC_BITS{1'b0}}};

    logic [PRW-1:0] out_prob;

    assign out_prob = m_axis_tdata[2*W+PRW-1:2*W];

    // clearing pass blocks input right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready during clearing pass");

    // one item at a time: no transfer in the cycle after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an input transfer");

    // probability never exceeds one
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> out_prob <= ONE_P)
        else $error("probability above one");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind quantum_state_vector_gates_core qsv_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_qsv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
